// ===== sv/telemetry_packet_deframer_core_macros.svh =====
// Assertion macros shared by the deframer modules.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef TELEMETRY_PACKET_DEFRAMER_CORE_MACROS_SVH
`define TELEMETRY_PACKET_DEFRAMER_CORE_MACROS_SVH

// Same-cycle implication
`define TPD_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define TPD_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/tpd_pkg.sv =====
// Package for the telemetry packet deframer: codes, constants, field layout,
// the CRC-16 byte step and the frame-completion bundle. No dependencies.
`timescale 1ns / 1ps

package tpd_pkg;

   // input command codes
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // register indexes
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_VALUES_ID = 1'b1;

   // register reset values
   localparam logic [15:0] TIMEOUT_RESET   = 16'd100;
   localparam logic [7:0]  VALUES_ID_RESET = 8'd4;

   // default sizing
   localparam int DEF_FRAME_BYTES = 512;
   localparam int DEF_HEAD_BYTES  = 64;

   // framing constants
   localparam logic [7:0]  START_SHORT   = 8'h02;
   localparam int          FOOTER_LEN    = 3;
   localparam int          MIN_CHECK_POS = 3;
   localparam logic [15:0] IDLE_MAX      = 16'hFFFF;
   localparam logic [15:0] CRC_POLY      = 16'h1021;

   // status codes
   localparam logic STATUS_GOOD    = 1'b0;
   localparam logic STATUS_BAD_CRC = 1'b1;

   // telemetry field layout (payload offsets, 4-byte flag)
   localparam int NUM_FIELDS = 11;
   localparam logic [3:0] LAST_FIELD = 4'd10;
   localparam int FIELD_SPAN = 53;
   localparam int SPAN_AW = $clog2(FIELD_SPAN);
   localparam int FIELD_OFFSET [NUM_FIELDS] = '{1, 3, 5, 9, 21, 23, 27, 29, 33, 45, 49};
   localparam bit FIELD_WIDE [NUM_FIELDS] = '{0, 0, 1, 1, 0, 1, 0, 1, 1, 1, 1};

   // completed-frame bundle handed to the result stage
   typedef struct packed {
      logic                            status;
      logic                            telemetry;
      logic [7:0]                      msg_id;
      logic [NUM_FIELDS-1:0][31:0]     fields;
   } frame_done_type;

   // CRC-16/XMODEM, one byte, MSB first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

endpackage

// ===== sv/tpd_frame_track.sv =====
// Deframer input stage: input word register, frame position tracking, CRC,
// payload head buffer and field extraction. Depends on tpd_pkg and the macros header.
`timescale 1ns / 1ps
`include "telemetry_packet_deframer_core_macros.svh"

module tpd_frame_track #(
   parameter int FRAME_BYTES = tpd_pkg::DEF_FRAME_BYTES,
   parameter int HEAD_BYTES  = tpd_pkg::DEF_HEAD_BYTES
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_command,
   input  logic [7:0]              req_rx_byte,
   input  logic [15:0]             timeout_ms,
   input  logic [7:0]              values_id,
   input  logic                    out_free,
   output logic                    done_valid,
   output tpd_pkg::frame_done_type done
);

   localparam int PW  = $clog2(FRAME_BYTES);
   localparam int PW1 = PW + 1;
   localparam int HAW = $clog2(HEAD_BYTES);
   localparam int FW  = $clog2(HEAD_BYTES + 1);

   // input word register
   logic       in_valid_ff;
   logic       in_cmd_ff;
   logic [7:0] in_byte_ff;

   // frame state
   logic [PW-1:0] frame_pos_ff, frame_pos_in;
   logic [15:0]   body_len_ff, body_len_in;
   logic          long_header_ff, long_header_in;
   logic [15:0]   crc_run_ff, crc_run_in;
   logic [7:0]    crc_high_ff, crc_high_in;
   logic [15:0]   idle_ms_ff, idle_ms_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [7:0]    head_ff [HEAD_BYTES];

   // per-word decode
   logic           is_byte, is_tick, timed_out, fire;
   logic [PW-1:0]  pos;
   logic [PW1-1:0] pos_next;
   logic [1:0]     hdr;
   logic [16:0]    pos_ext, hdr_ext, len_ext, q, total;
   logic           in_region, short_pos, overflow, reached, frame_end, complete;
   logic           head_we;
   logic [HAW-1:0] head_addr;
   logic [7:0]     head_rd [tpd_pkg::FIELD_SPAN];

   assign is_byte   = in_valid_ff && (in_cmd_ff == tpd_pkg::CMD_BYTE);
   assign is_tick   = in_valid_ff && (in_cmd_ff == tpd_pkg::CMD_TICK);
   assign timed_out = idle_ms_ff > timeout_ms;
   assign pos       = timed_out ? '0 : frame_pos_ff;
   assign pos_next  = {1'b0, pos} + PW1'(1);
   assign hdr       = long_header_ff ? 2'd3 : 2'd2;
   assign pos_ext   = 17'(pos);
   assign hdr_ext   = 17'(hdr);
   assign len_ext   = {1'b0, body_len_ff};
   assign in_region = pos_ext >= hdr_ext;
   assign q         = pos_ext - hdr_ext;
   assign total     = hdr_ext + len_ext + 17'(tpd_pkg::FOOTER_LEN);

   // end of frame: oversize drop takes precedence over completion
   assign short_pos = pos_next <= PW1'(tpd_pkg::MIN_CHECK_POS);
   assign overflow  = pos_next >= PW1'(FRAME_BYTES);
   assign reached   = 17'(pos_next) >= total;
   assign frame_end = !short_pos && (overflow || reached);
   assign complete  = is_byte && !short_pos && !overflow && reached;

   // a completing byte waits while the result stage still holds a frame
   assign fire       = in_valid_ff && (!complete || out_free);
   assign req_stall  = in_valid_ff && !fire;
   assign done_valid = fire && complete;

   // payload head write
   assign head_we   = fire && is_byte && (pos != '0) && in_region && (q < len_ext)
                      && (q < 17'(HEAD_BYTES));
   assign head_addr = q[HAW-1:0];

   // next state
   always_comb begin
      frame_pos_in   = frame_pos_ff;
      body_len_in    = body_len_ff;
      long_header_in = long_header_ff;
      crc_run_in     = crc_run_ff;
      crc_high_in    = crc_high_ff;
      idle_ms_in     = idle_ms_ff;
      fill_in        = fill_ff;
      if (fire && is_tick) begin
         idle_ms_in = (idle_ms_ff == tpd_pkg::IDLE_MAX) ? idle_ms_ff : idle_ms_ff + 16'd1;
      end
      if (fire && is_byte) begin
         idle_ms_in = '0;
         priority if (pos == '0) begin
            long_header_in = in_byte_ff != tpd_pkg::START_SHORT;
            body_len_in    = '0;
            crc_run_in     = '0;
            crc_high_in    = '0;
            fill_in        = '0;
         end else if (pos == PW'(1)) begin
            body_len_in = long_header_ff ? {in_byte_ff, 8'h00} : {8'h00, in_byte_ff};
         end else if (pos == PW'(2) && long_header_ff) begin
            body_len_in = {body_len_ff[15:8], in_byte_ff};
         end else if (in_region) begin
            if (q < len_ext) begin
               crc_run_in = tpd_pkg::crc_byte(crc_run_ff, in_byte_ff);
               if (q < 17'(HEAD_BYTES)) begin
                  fill_in = fill_ff + FW'(1);
               end
            end else if (q == len_ext) begin
               crc_high_in = in_byte_ff;
            end else if (q == len_ext + 17'd1) begin
               crc_run_in = crc_run_ff ^ {crc_high_ff, in_byte_ff};
            end
         end
         frame_pos_in = frame_end ? '0 : pos_next[PW-1:0];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         frame_pos_ff   <= '0;
         body_len_ff    <= '0;
         long_header_ff <= 1'b0;
         crc_run_ff     <= '0;
         crc_high_ff    <= '0;
         idle_ms_ff     <= '0;
         fill_ff        <= '0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         frame_pos_ff   <= frame_pos_in;
         body_len_ff    <= body_len_in;
         long_header_ff <= long_header_in;
         crc_run_ff     <= crc_run_in;
         crc_high_ff    <= crc_high_in;
         idle_ms_ff     <= idle_ms_in;
         fill_ff        <= fill_in;
      end
   end

   // input word payload
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_cmd_ff  <= req_command;
         in_byte_ff <= req_rx_byte;
      end
   end

   // head buffer; entries at or past the fill count read as zero
   always_ff @(posedge clock) begin
      if (head_we) begin
         head_ff[head_addr] <= in_byte_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < tpd_pkg::FIELD_SPAN; i++) begin
         head_rd[i] = (FW'(i) < fill_ff) ? head_ff[HAW'(i)] : 8'h00;
      end
   end

   // completion bundle
   always_comb begin
      int o;
      o = 0;
      done.status    = (crc_run_ff != '0) ? tpd_pkg::STATUS_BAD_CRC : tpd_pkg::STATUS_GOOD;
      done.msg_id    = head_rd[0];
      done.telemetry = (done.status == tpd_pkg::STATUS_GOOD) && (head_rd[0] == values_id);
      for (int k = 0; k < tpd_pkg::NUM_FIELDS; k++) begin
         o = tpd_pkg::FIELD_OFFSET[k];
         if (tpd_pkg::FIELD_WIDE[k]) begin
            done.fields[k] = {head_rd[tpd_pkg::SPAN_AW'(o)],
                              head_rd[tpd_pkg::SPAN_AW'(o + 1)],
                              head_rd[tpd_pkg::SPAN_AW'(o + 2)],
                              head_rd[tpd_pkg::SPAN_AW'(o + 3)]};
         end else begin
            done.fields[k] = {{16{head_rd[tpd_pkg::SPAN_AW'(o)][7]}},
                              head_rd[tpd_pkg::SPAN_AW'(o)],
                              head_rd[tpd_pkg::SPAN_AW'(o + 1)]};
         end
      end
   end

   // checks
   `TPD_ASSERT_IMP(a_fill_range, clock, reset, 1'b1, fill_ff <= FW'(HEAD_BYTES), "fill count past head size")
   `TPD_ASSERT_NXT(a_done_clears_pos, clock, reset, done_valid, frame_pos_ff == '0, "frame position not cleared after completion")
   `TPD_ASSERT_NXT(a_tick_keeps_pos, clock, reset, fire && is_tick, $stable(frame_pos_ff) && $stable(crc_run_ff), "tick changed frame state")

endmodule

// ===== sv/tpd_result_stage.sv =====
// Deframer result stage: holds one completed frame and emits its result words, one per cycle
// while rsp_stall is low, eleven for a telemetry frame. Depends on tpd_pkg and the macros header.
`timescale 1ns / 1ps
`include "telemetry_packet_deframer_core_macros.svh"

module tpd_result_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    done_valid,
   input  tpd_pkg::frame_done_type done,
   output logic                    out_free,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_status,
   output logic [7:0]              rsp_msg_id,
   output logic                    rsp_has_value,
   output logic [3:0]              rsp_field_index,
   output logic signed [31:0]      rsp_field_value,
   output logic                    rsp_last
);

   logic                                    valid_ff;
   logic [3:0]                              idx_ff;
   logic                                    tele_ff;
   logic                                    status_ff;
   logic [7:0]                              msg_ff;
   logic [tpd_pkg::NUM_FIELDS-1:0][31:0]    fields_ff, fields_in;
   logic                                    take, last;

   assign take     = valid_ff && !rsp_stall;
   assign last     = !tele_ff || (idx_ff == tpd_pkg::LAST_FIELD);
   assign out_free = !valid_ff || (take && last);

   // field queue shifts down as words are taken
   always_comb begin
      for (int k = 0; k < tpd_pkg::NUM_FIELDS - 1; k++) begin
         fields_in[k] = fields_ff[k + 1];
      end
      fields_in[tpd_pkg::NUM_FIELDS-1] = fields_ff[tpd_pkg::NUM_FIELDS-1];
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (done_valid) begin
         valid_ff <= 1'b1;
         idx_ff   <= '0;
      end else if (take) begin
         if (last) begin
            valid_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + 4'd1;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (done_valid) begin
         tele_ff   <= done.telemetry;
         status_ff <= done.status;
         msg_ff    <= done.msg_id;
         fields_ff <= done.fields;
      end else if (take && !last) begin
         fields_ff <= fields_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_msg_id      = msg_ff;
   assign rsp_has_value   = tele_ff;
   assign rsp_field_index = tele_ff ? idx_ff : 4'd0;
   assign rsp_field_value = tele_ff ? signed'(fields_ff[0]) : 32'sd0;
   assign rsp_last        = last;

   // checks
   `TPD_ASSERT_IMP(a_idx_range, clock, reset, valid_ff, idx_ff <= tpd_pkg::LAST_FIELD, "field index past last field")
   `TPD_ASSERT_NXT(a_more_follow, clock, reset, take && !last, valid_ff, "result words lost mid-frame")
   `TPD_ASSERT_NXT(a_idx_step, clock, reset, take && !last, idx_ff == $past(idx_ff) + 4'd1, "field index did not advance by one")

endmodule

// ===== sv/telemetry_packet_deframer_core.sv =====
// Channel  | ports                      | direction | payload
// req      | req_valid / req_stall      | in        | req_command, req_rx_byte
// rsp      | rsp_valid / rsp_stall      | out       | status, msg_id, has_value, field_index,
//          |                            |           | field_value, last
// csr      | csr_we                     | in        | csr_index, csr_wdata
//
// One input word per cycle while req_stall is low: a word is registered, then processed.
// A completed frame moves from the input register into the result stage once its
// last byte is processed; a telemetry frame then yields eleven result words, one
// per cycle while rsp_stall is low. A byte that completes another frame waits in
// the input register until the last word of the previous frame is taken. Ticks
// and other bytes pass. Reset is synchronous; the head buffer needs no sweep.
// Top level of the telemetry packet deframer; instantiates tpd_frame_track and
// tpd_result_stage, holds the configuration registers. Depends on tpd_pkg.
`timescale 1ns / 1ps

module telemetry_packet_deframer_core #(
   parameter int FRAME_BYTES = tpd_pkg::DEF_FRAME_BYTES,
   parameter int HEAD_BYTES  = tpd_pkg::DEF_HEAD_BYTES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_command,
   input  logic [7:0]                       req_rx_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_status,
   output logic [7:0]                       rsp_msg_id,
   output logic                             rsp_has_value,
   output logic [3:0]                       rsp_field_index,
   output logic signed [31:0]               rsp_field_value,
   output logic                             rsp_last,
   input  logic                             csr_we,
   input  logic [tpd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tpd_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   logic [15:0]             timeout_ff;
   logic [7:0]              values_id_ff;
   logic                    out_free;
   logic                    done_valid;
   tpd_pkg::frame_done_type done;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= tpd_pkg::TIMEOUT_RESET;
         values_id_ff <= tpd_pkg::VALUES_ID_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            tpd_pkg::CSR_TIMEOUT:   timeout_ff   <= csr_wdata[15:0];
            tpd_pkg::CSR_VALUES_ID: values_id_ff <= csr_wdata[7:0];
         endcase
      end
   end

   tpd_frame_track #(
      .FRAME_BYTES (FRAME_BYTES),
      .HEAD_BYTES  (HEAD_BYTES)
   ) u_track (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_command (req_command),
      .req_rx_byte (req_rx_byte),
      .timeout_ms  (timeout_ff),
      .values_id   (values_id_ff),
      .out_free    (out_free),
      .done_valid  (done_valid),
      .done        (done)
   );

   tpd_result_stage u_result (
      .clock           (clock),
      .reset           (reset),
      .done_valid      (done_valid),
      .done            (done),
      .out_free        (out_free),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_msg_id      (rsp_msg_id),
      .rsp_has_value   (rsp_has_value),
      .rsp_field_index (rsp_field_index),
      .rsp_field_value (rsp_field_value),
      .rsp_last        (rsp_last)
   );

endmodule

// ===== tb/sv/telemetry_packet_deframer_core_tb.sv =====
// Self-checking bench for telemetry_packet_deframer_core: sends byte and tick words and
// predicts every result word from a model of the framing, CRC and field decode.
// Depends on tpd_pkg and telemetry_packet_deframer_core.
`timescale 1ns / 1ps

// one result word as the response channel carries it
typedef struct {
   logic        status;
   logic [7:0]  msg_id;
   logic        has_value;
   logic [3:0]  field_index;
   logic [31:0] field_value;
   logic        last;
} deframe_word_type;

// Tracks the frame state of the block and holds the result words still due
class deframer_scoreboard;
   logic [15:0]      timeout_ms;
   logic [7:0]       telemetry_id;
   int unsigned      frame_pos;
   logic [15:0]      body_len;
   bit               long_header;
   logic [15:0]      crc_acc;
   logic [7:0]       crc_high;
   logic [15:0]      idle_ms;
   logic [7:0]       head [tpd_pkg::DEF_HEAD_BYTES];
   deframe_word_type words_due [$];
   int unsigned      words_made;
   int               errors;

   function new();
      timeout_ms = tpd_pkg::TIMEOUT_RESET;
      telemetry_id = tpd_pkg::VALUES_ID_RESET;
      frame_pos = 0;
      body_len = 16'h0000;
      long_header = 1'b0;
      crc_acc = 16'h0000;
      crc_high = 8'h00;
      idle_ms = 16'h0000;
      foreach (head[i]) head[i] = 8'h00;
      words_made = 0;
      errors = 0;
   endfunction

   // CRC-16/XMODEM, one byte, MSB first
   static function logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      repeat (8) c = c[15] ? ((c << 1) ^ tpd_pkg::CRC_POLY) : (c << 1);
      return c;
   endfunction

   function void set_reg(logic [tpd_pkg::CSR_IDX_W-1:0] idx, logic [15:0] data);
      if (idx == tpd_pkg::CSR_TIMEOUT)
         timeout_ms = data;
      else
         telemetry_id = data[7:0];
   endfunction

   function void push_word(logic st, logic hv, logic [3:0] idx, logic [31:0] val, logic lst);
      deframe_word_type w;
      w.status = st;
      w.msg_id = head[0];
      w.has_value = hv;
      w.field_index = idx;
      w.field_value = val;
      w.last = lst;
      words_due.push_back(w);
      words_made++;
   endfunction

   // advance the frame state by one accepted word and queue what it completes
   function void note_word(logic cmd, logic [7:0] b);
      int unsigned hdr, q, total;
      int unsigned offs [tpd_pkg::NUM_FIELDS];
      bit          wide [tpd_pkg::NUM_FIELDS];
      logic [31:0] v;
      if (cmd == tpd_pkg::CMD_TICK) begin
         if (idle_ms != tpd_pkg::IDLE_MAX) idle_ms++;
         return;
      end
      // a byte after too long a gap starts a new frame; the gap is checked first
      if (idle_ms > timeout_ms) frame_pos = 0;
      idle_ms = 16'h0000;
      hdr = long_header ? 3 : 2;
      if (frame_pos == 0) begin
         long_header = (b != tpd_pkg::START_SHORT);
         body_len = 16'h0000;
         crc_acc = 16'h0000;
         crc_high = 8'h00;
         foreach (head[i]) head[i] = 8'h00;
      end else if (frame_pos == 1) begin
         body_len = long_header ? {b, 8'h00} : {8'h00, b};
      end else if (frame_pos == 2 && long_header) begin
         body_len[7:0] = b;
      end else if (frame_pos >= hdr) begin
         q = frame_pos - hdr;
         if (q < body_len) begin
            crc_acc = crc16_step(crc_acc, b);
            if (q < tpd_pkg::DEF_HEAD_BYTES) head[q] = b;
         end else if (q == body_len) begin
            crc_high = b;
         end else if (q == body_len + 1) begin
            crc_acc ^= {crc_high, b};
         end
      end
      frame_pos++;
      if (frame_pos <= tpd_pkg::MIN_CHECK_POS) return;
      // oversized frame goes away without a word, even on its last byte
      if (frame_pos >= tpd_pkg::DEF_FRAME_BYTES) begin
         frame_pos = 0;
         return;
      end
      total = (long_header ? 3 : 2) + body_len + tpd_pkg::FOOTER_LEN;
      if (frame_pos < total) return;
      frame_pos = 0;
      if (crc_acc != 16'h0000) begin
         push_word(tpd_pkg::STATUS_BAD_CRC, 1'b0, 4'd0, 32'd0, 1'b1);
         return;
      end
      if (head[0] != telemetry_id) begin
         push_word(tpd_pkg::STATUS_GOOD, 1'b0, 4'd0, 32'd0, 1'b1);
         return;
      end
      // telemetry: big-endian fields, the 16-bit ones sign-extended
      offs = '{1, 3, 5, 9, 21, 23, 27, 29, 33, 45, 49};
      wide = '{0, 0, 1, 1, 0, 1, 0, 1, 1, 1, 1};
      for (int k = 0; k < tpd_pkg::NUM_FIELDS; k++) begin
         if (wide[k])
            v = {head[offs[k]], head[offs[k]+1], head[offs[k]+2], head[offs[k]+3]};
         else
            v = {{16{head[offs[k]][7]}}, head[offs[k]], head[offs[k]+1]};
         push_word(tpd_pkg::STATUS_GOOD, 1'b1, 4'(k), v, 4'(k) == tpd_pkg::LAST_FIELD);
      end
   endfunction

   function void compare_field(string name, logic [31:0] due, logic [31:0] got);
      if (got !== due) begin
         $error("%s: expected %0h, got %0h", name, due, got);
         errors++;
      end
   endfunction

   function void check_word(deframe_word_type got);
      deframe_word_type due;
      if (words_due.size() == 0) begin
         $error("result word with none due: msg_id %0h index %0d value %0h",
                got.msg_id, got.field_index, got.field_value);
         errors++;
         return;
      end
      due = words_due.pop_front();
      compare_field("status", due.status, got.status);
      compare_field("msg_id", due.msg_id, got.msg_id);
      compare_field("has_value", due.has_value, got.has_value);
      compare_field("field_index", due.field_index, got.field_index);
      compare_field("field_value", due.field_value, got.field_value);
      compare_field("last", due.last, got.last);
   endfunction
endclass

module telemetry_packet_deframer_core_tb;

   localparam int IDLE_LIMIT    = 3000;  // cycles in a row with no word moving
   localparam int LONG_HOLD     = 300;   // receiver hold that backs the block up
   localparam int SETTLE_CYCLES = 8;     // settle wait once no result word is due

   logic clock = 1'b0;
   logic reset;

   logic req_valid;
   logic req_stall;
   logic req_command;
   logic [7:0] req_rx_byte;

   logic rsp_valid;
   logic rsp_stall;
   logic rsp_status;
   logic [7:0] rsp_msg_id;
   logic rsp_has_value;
   logic [3:0] rsp_field_index;
   logic signed [31:0] rsp_field_value;
   logic rsp_last;

   logic csr_we;
   logic [tpd_pkg::CSR_IDX_W-1:0] csr_index;
   logic [tpd_pkg::CSR_DATA_W-1:0] csr_wdata;

   deframer_scoreboard sb = new;
   bit req_idle_on;
   bit rsp_idle_on;
   bit hold_req;
   int unsigned words_sent;

   telemetry_packet_deframer_core i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_msg_id      (rsp_msg_id),
      .rsp_has_value   (rsp_has_value),
      .rsp_field_index (rsp_field_index),
      .rsp_field_value (rsp_field_value),
      .rsp_last        (rsp_last),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // receiver: random stall bursts, plus one long hold on request
   initial begin : rsp_stall_drive
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (rsp_idle_on && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 18)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // check every result word taken
   always @(posedge clock) begin : rsp_monitor
      deframe_word_type seen;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen.status = rsp_status;
         seen.msg_id = rsp_msg_id;
         seen.has_value = rsp_has_value;
         seen.field_index = rsp_field_index;
         seen.field_value = rsp_field_value;
         seen.last = rsp_last;
         sb.check_word(seen);
      end
   end

   // watchdog: ends the run when nothing moves for too long
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || csr_we || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("telemetry_packet_deframer_core_tb: done, errors");
      $finish;
   end

   // offer one word, optionally after a gap, and hold it until taken
   task automatic send_word(input logic cmd, input logic [7:0] b);
      if (req_idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_word(cmd, b);
      words_sent++;
   endtask

   task automatic send_ticks(input int unsigned n);
      repeat (n) send_word(tpd_pkg::CMD_TICK, 8'($urandom));
   endtask

   // byte inside a frame; sometimes ticks first, never more than the timeout allows
   task automatic send_framed_byte(input logic [7:0] b);
      int unsigned pad;
      if ($urandom_range(0, 15) == 0) begin
         pad = (sb.timeout_ms < 16'd2) ? sb.timeout_ms : 2;
         if (sb.timeout_ms <= 16'd20 && $urandom_range(0, 1))
            pad = sb.timeout_ms;
         else
            pad = $urandom_range(0, pad);
         send_ticks(pad);
      end
      send_word(tpd_pkg::CMD_BYTE, b);
   endtask

   // start, length, payload led by its id, CRC, end byte; cut >= 0 stops after that
   // many payload bytes, bad_crc flips one CRC bit
   task automatic send_frame(input logic [7:0] start, input logic [15:0] len,
                             input logic [7:0] id, input bit bad_crc, input int cut = -1);
      logic [7:0] body [$];
      logic [15:0] crc;
      int unsigned fill;
      fill = $urandom_range(0, 7);
      crc = 16'h0000;
      for (int i = 0; i < len; i++) begin
         case (fill)
            0: body.push_back(8'h00);
            1: body.push_back(8'hFF);
            2: body.push_back((i % 2 == 1) ? 8'h7F : 8'h80);
            default: body.push_back(8'($urandom));
         endcase
      end
      if (len != 0) body[0] = id;
      foreach (body[i]) crc = tpd_pkg::crc_byte(crc, body[i]);
      if (bad_crc) crc ^= 16'h0001 << $urandom_range(0, 15);
      send_framed_byte(start);
      if (start != tpd_pkg::START_SHORT) send_framed_byte(len[15:8]);
      send_framed_byte(len[7:0]);
      foreach (body[i])
         if (cut < 0 || i < cut) send_framed_byte(body[i]);
      if (cut >= 0) return;
      send_framed_byte(crc[15:8]);
      send_framed_byte(crc[7:0]);
      send_framed_byte(8'($urandom));
   endtask

   // drop valid and wait until every due word has come and the pipe is quiet
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.words_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_config(input logic [15:0] timeout, input logic [7:0] id);
      logic [15:0] id_word;
      id_word = {8'($urandom), id};
      csr_we <= 1'b1;
      csr_index <= tpd_pkg::CSR_TIMEOUT;
      csr_wdata <= timeout;
      @(posedge clock);
      csr_index <= tpd_pkg::CSR_VALUES_ID;
      csr_wdata <= id_word;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_reg(tpd_pkg::CSR_TIMEOUT, timeout);
      sb.set_reg(tpd_pkg::CSR_VALUES_ID, id_word);
   endtask

   // one register setting, then mostly well-formed frames with random content
   task automatic run_phase(input logic [15:0] timeout, input logic [7:0] id,
                            input int unsigned min_words, input int unsigned min_results);
      int unsigned words0, made0, pick;
      logic [7:0] start, other;
      logic [15:0] len;
      wait_drained();
      write_config(timeout, id);
      words0 = words_sent;
      made0 = sb.words_made;
      while (words_sent - words0 < min_words || sb.words_made - made0 < min_results) begin
         pick = $urandom_range(0, 99);
         start = $urandom_range(0, 1) ? tpd_pkg::START_SHORT : 8'($urandom);
         other = 8'($urandom);
         if (other == id) other = ~id;
         if (pick < 35) begin
            len = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(1, 20))
                                              : 16'($urandom_range(53, 58));
            send_frame(start, len, id, 1'b0);
         end else if (pick < 70) begin
            send_frame(start, 16'($urandom_range(0, 8)), other, 1'b0);
         end else if (pick < 82) begin
            send_frame(start, 16'($urandom_range(0, 16)), $urandom_range(0, 1) ? id : other,
                       1'b1);
         end else if (pick < 90 || timeout > 16'd20) begin
            send_ticks($urandom_range(1, 4));
         end else begin
            // broken sequence, then a gap long enough to restart framing
            if (pick < 95)
               send_frame(start, 16'($urandom_range(1, 20)), id, 1'b0, $urandom_range(0, 10));
            else
               repeat ($urandom_range(1, 4)) send_word(1'($urandom_range(0, 1)), 8'($urandom));
            send_ticks(32'(timeout) + 1);
         end
      end
   endtask

   initial begin : stimulus
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_command <= tpd_pkg::CMD_BYTE;
      req_rx_byte <= 8'h00;
      csr_we <= 1'b0;
      csr_index <= tpd_pkg::CSR_TIMEOUT;
      csr_wdata <= 16'h0000;
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      hold_req = 1'b0;
      words_sent = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed, registers at reset values
      send_frame(tpd_pkg::START_SHORT, 16'd0, 8'h00, 1'b0);        // empty payload
      send_frame(8'hFF, 16'd3, tpd_pkg::VALUES_ID_RESET, 1'b0);    // short telemetry
      send_frame(8'h00, 16'd1, 8'h7F, 1'b1);                       // bad CRC, long header
      send_ticks(2);

      // zero timeout: any tick between bytes restarts the frame
      run_phase(16'd0, 8'd4, 30, 4);

      // largest timeout and largest id
      run_phase(16'hFFFF, 8'd255, 30, 4);

      // id zero: an empty payload decodes as telemetry
      run_phase(16'd7, 8'd0, 30, 4);
      send_frame(8'h05, 16'd0, 8'h00, 1'b0);

      // receiver holds off while short telemetry frames keep coming, so the input stalls
      run_phase(16'd100, 8'd4, 30, 4);
      hold_req = 1'b1;
      req_idle_on = 1'b0;
      repeat (3) send_frame(tpd_pkg::START_SHORT, 16'($urandom_range(1, 8)), 8'd4, 1'b0);
      req_idle_on = 1'b1;

      run_phase(16'd12, 8'($urandom), 30, 4);

      // closing stretch at full rate on both sides
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      run_phase(16'd3, 8'd4, 30, 4);
      wait_drained();

      if (sb.errors == 0 && sb.words_due.size() == 0)
         $display("telemetry_packet_deframer_core_tb: done, clean");
      else
         $display("telemetry_packet_deframer_core_tb: done, errors");
      $finish;
   end

endmodule
